/* src/sdgr_pkg.sv */
// Package: constants and glyph table for the signed decimal glyph renderer.
package sdgr_pkg;

  localparam int unsigned MAG_W       = 16;
  localparam int unsigned QUO_W       = 12;
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [PROD_W-1:0] RECIP_10 = 32'd52429;

  localparam logic [6:0] START_COLUMN = 7'd102;
  localparam logic [7:0] PAGE_UPPER   = 8'hB7;
  localparam logic [7:0] PAGE_LOWER   = 8'hB6;
  localparam logic [4:0] COL_HIGH_CMD = 5'h10;
  localparam logic [2:0] SLOT_FIRST   = 3'd1;
  localparam logic [2:0] SLOT_MAX     = 3'd6;

  localparam logic [3:0] GLYPH_ZERO  = 4'd0;
  localparam logic [3:0] GLYPH_PLUS  = 4'd10;
  localparam logic [3:0] GLYPH_MINUS = 4'd11;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic [3:0]       rem;
  } div_res_t;

  // Five glyph columns for one half of a symbol, left column most significant.
  function automatic logic [39:0] glyph_cols(input logic [3:0] g, input logic lower);
    logic [79:0] row;
    begin
      unique case (g)
        4'd0:    row = {40'h7F8080807F, 40'h0080808000};
        4'd1:    row = {40'h10204080FF, 40'h0000000080};
        4'd2:    row = {40'h4182848870, 40'h8080808080};
        4'd3:    row = {40'h4180888877, 40'h0080808000};
        4'd4:    row = {40'hF8080808FF, 40'h0000000080};
        4'd5:    row = {40'hF188888887, 40'h0080808000};
        4'd6:    row = {40'h7F88888847, 40'h0080808000};
        4'd7:    row = {40'h80808080FF, 40'h0000000080};
        4'd8:    row = {40'h7788888877, 40'h0080808000};
        4'd9:    row = {40'h718888887F, 40'h0080808000};
        4'd10:   row = {40'h08083E0808, 40'h0000000000};
        4'd11:   row = {40'h0808080808, 40'h0000000000};
        default: row = 80'h0;
      endcase
      glyph_cols = lower ? row[39:0] : row[79:40];
    end
  endfunction

endpackage

/* src/sdgr_div10.sv */
// Shared divide-by-ten unit: reciprocal multiply, registered, remainder by shift-add.
module sdgr_div10 import sdgr_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic [MAG_W-1:0] n,
  output div_res_t         res
);

  logic [MAG_W-1:0]  n_reg;
  logic [QUO_W-1:0]  quo_reg;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  times_ten;
  logic [MAG_W-1:0]  diff;

  assign prod = {{(PROD_W-MAG_W){1'b0}}, n} * RECIP_10;

  always_ff @(posedge clk) begin
    if (load) begin
      n_reg   <= n;
      quo_reg <= prod[RECIP_SHIFT +: QUO_W];
    end
  end

  assign times_ten = {1'b0, quo_reg, 3'b000} + {3'b000, quo_reg, 1'b0};
  assign diff      = n_reg - times_ten;
  assign res.quo   = quo_reg;
  assign res.rem   = diff[3:0];

endmodule

/* src/signed_decimal_glyph_renderer.sv */
// Top level: sequencer that renders a signed value as LCD glyph write records.
//
//  channel  | handshake          | fields
//  ---------+--------------------+--------------------------------------------------
//  input    | start / busy       | value
//  result   | strobe (one cycle) | page_command, column_low_command,
//           |                    | column_high_command, pixel_bytes, last_record
//
// Each digit goes through the divide-by-ten unit and then gives an upper and a lower
// record; a sign record pair follows the last digit, and a zero value renders one zero
// glyph with no sign. Busy is high from acceptance until the final record.
// Synchronous reset returns the sequencer to idle. Results cannot be stalled:
// every record is shown for exactly one cycle with strobe high.
module signed_decimal_glyph_renderer import sdgr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] value,
  output logic               strobe,
  output logic [7:0]         page_command,
  output logic [3:0]         column_low_command,
  output logic [4:0]         column_high_command,
  output logic [63:0]        pixel_bytes,
  output logic               last_record
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HI   = 2'd2;
  localparam logic [1:0] ST_LO   = 2'd3;

  logic [1:0]       state;
  logic [MAG_W-1:0] mag;
  logic             negative;
  logic [2:0]       slot;
  logic [3:0]       glyph;
  logic             last;

  logic [MAG_W-1:0] raw;
  logic [MAG_W-1:0] abs_val;
  logic [MAG_W-1:0] div_n;
  logic             div_load;
  div_res_t         div_res;
  logic [6:0]       column;

  assign raw     = value;
  assign abs_val = raw[MAG_W-1] ? (~raw + 16'd1) : raw;

  assign div_load = ((state == ST_IDLE) && start) ||
                    ((state == ST_LO) && !last && (mag != '0));
  assign div_n    = (state == ST_IDLE) ? abs_val : mag;

  sdgr_div10 u_div10 (
    .clk  (clk),
    .load (div_load),
    .n    (div_n),
    .res  (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      last  <= 1'b0;
      slot  <= SLOT_FIRST;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            negative <= raw[MAG_W-1];
            slot     <= SLOT_FIRST;
            if (raw == '0) begin
              glyph <= GLYPH_ZERO;
              last  <= 1'b1;
              state <= ST_HI;
            end else begin
              last  <= 1'b0;
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          glyph <= div_res.rem;
          mag   <= {{(MAG_W-QUO_W){1'b0}}, div_res.quo};
          state <= ST_HI;
        end
        ST_HI: begin
          state <= ST_LO;
        end
        ST_LO: begin
          if (last) begin
            state <= ST_IDLE;
          end else if (mag != '0) begin
            slot  <= slot + 3'd1;
            state <= ST_DIV;
          end else begin
            slot  <= slot + 3'd1;
            glyph <= negative ? GLYPH_MINUS : GLYPH_PLUS;
            last  <= 1'b1;
            state <= ST_HI;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy   = (state != ST_IDLE);
  assign strobe = (state == ST_HI) || (state == ST_LO);
  assign column = START_COLUMN - {1'b0, slot, 3'b000};

  assign page_command        = (state == ST_LO) ? PAGE_LOWER : PAGE_UPPER;
  assign column_low_command  = column[3:0];
  assign column_high_command = COL_HIGH_CMD | {2'b00, column[6:4]};
  assign pixel_bytes         = {24'h0, glyph_cols(glyph, state == ST_LO)};
  assign last_record         = last && (state == ST_LO);

  a_hi_then_lo: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HI) |=> (state == ST_LO))
    else $error("upper record not followed by lower record");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_record) |=> !busy)
    else $error("busy after final record");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ((slot >= SLOT_FIRST) && (slot <= SLOT_MAX)))
    else $error("symbol slot out of range");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !strobe) || (busy && page_command == PAGE_UPPER))
    else $error("transaction accepted without starting work");

endmodule
